>>> rtl/bdsm_pkg.sv
`default_nettype none

package bdsm_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_ENABLES    = 3'd0;
    localparam logic [2:0] CFG_CAL_FACTOR = 3'd1;
    localparam logic [2:0] CFG_MIN_MV     = 3'd2;
    localparam logic [2:0] CFG_REF_MV     = 3'd3;
    localparam logic [2:0] CFG_BASE_DT    = 3'd4;
    localparam logic [2:0] CFG_DT_SENS    = 3'd5;
    localparam logic [2:0] CFG_GRACE      = 3'd6;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier operand and product widths
    localparam int OPA_W  = 23;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_MV,
        ST_VOLT,
        ST_MUL_DT,
        ST_CORR
    } seq_state_t;

    typedef struct packed {
        logic power_up;
        logic dormant;
        logic fresh_loss;
        logic loss_pending;
    } acc_status_t;

endpackage

`default_nettype wire

>>> rtl/bdsm_mul.sv
`default_nettype none

module bdsm_mul (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [bdsm_pkg::OPA_W-1:0]   op_a,
    input  wire logic signed [bdsm_pkg::OPB_W-1:0]   op_b,
    output logic signed      [bdsm_pkg::PROD_W-1:0]  prod
);
    import bdsm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/bdsm_acc.sv
`default_nettype none

module bdsm_acc (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  commit,
    input  wire logic                  supervise_en,
    input  wire logic [31:0]           now_ms,
    input  wire logic                  acc_on,
    input  wire logic                  display_ready,
    input  wire logic [23:0]           grace_ms,
    input  wire logic [23:0]           timeout_ms,
    output bdsm_pkg::acc_status_t      status_next
);
    import bdsm_pkg::*;

    logic        seen_reg, sleep_reg, just_lost_reg, pending_reg, armed_reg;
    logic        seen_next, sleep_next, just_lost_next, pending_next, armed_next;
    logic [31:0] loss_time_reg, loss_time_next;
    logic [31:0] elapsed;
    logic        rdy;

    always_comb begin
        seen_next      = seen_reg;
        sleep_next     = sleep_reg;
        just_lost_next = just_lost_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        loss_time_next = loss_time_reg;
        rdy            = display_ready;
        elapsed        = 32'd0;
        if (!supervise_en || acc_on) begin
            seen_next      = 1'b1;
            sleep_next     = 1'b0;
            just_lost_next = 1'b0;
            pending_next   = 1'b0;
            armed_next     = 1'b0;
            if (supervise_en) begin
                loss_time_next = 32'd0;
            end
        end else begin
            // falling edge of ACC: arm the timer, readiness drops on this word
            if (seen_reg) begin
                seen_next      = 1'b0;
                loss_time_next = now_ms;
                armed_next     = 1'b1;
                just_lost_next = 1'b1;
                pending_next   = 1'b1;
                rdy            = 1'b0;
            end
            elapsed = now_ms - loss_time_next;
            if (!sleep_reg && armed_next) begin
                if ((rdy && elapsed >= {8'd0, grace_ms}) || elapsed >= {8'd0, timeout_ms}) begin
                    sleep_next     = 1'b1;
                    just_lost_next = 1'b0;
                    pending_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b1;
            sleep_reg     <= 1'b0;
            just_lost_reg <= 1'b0;
            pending_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            loss_time_reg <= 32'd0;
        end else if (commit) begin
            seen_reg      <= seen_next;
            sleep_reg     <= sleep_next;
            just_lost_reg <= just_lost_next;
            pending_reg   <= pending_next;
            armed_reg     <= armed_next;
            loss_time_reg <= loss_time_next;
        end
    end

    assign status_next.power_up     = seen_next;
    assign status_next.dormant      = sleep_next;
    assign status_next.fresh_loss   = just_lost_next;
    assign status_next.loss_pending = pending_next;

endmodule

`default_nettype wire

>>> rtl/battery_deadtime_and_sleep_monitor_core.sv
`default_nettype none

// Battery voltage and dead-time monitor with ACC-loss sleep supervision.
// Input channel (s_valid/s_ready) takes one supervision word per tick: time
// stamp, converter sample with its valid flag, ACC level and display-ready.
// Result channel (m_valid/m_ready) returns one word per input word: voltage
// in millivolts, corrected injector dead time and four ACC/sleep flags.
// The user must write configuration through cfg_we/cfg_addr/cfg_wdata only
// while idle; the block does not enforce it. There is no read-back and writes
// take effect at once. Each word passes the steps MUL_MV, VOLT, MUL_DT and
// CORR, then the output register; the single shared multiplier is used twice
// per word (scaling, then the dead-time correction) with a register stage
// between the uses. s_ready is high only while the sequencer is idle.
// The result waits in an output register; if the receiver stalls with a
// result still held, the finished word waits in the last step and the next
// input is not taken until the held result has been read.
// Synchronous active-low reset sets configuration and state to defaults,
// marks ACC present with no timer running and empties the output register.
module battery_deadtime_and_sleep_monitor_core #(
    parameter int MAX_DEAD_TIME_US = 2000
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [bdsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bdsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [31:0]                    s_now_ms,
    input  wire logic [11:0]                    s_adc_raw,
    input  wire logic                           s_adc_valid,
    input  wire logic                           s_acc_on,
    input  wire logic                           s_display_ready,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [15:0]                         m_battery_mv,
    output logic [11:0]                         m_dead_time_us,
    output logic                                m_acc_present,
    output logic                                m_dormant,
    output logic                                m_acc_just_lost,
    output logic                                m_loss_pending
);
    import bdsm_pkg::*;

    localparam logic [11:0] MaxDt = 12'(MAX_DEAD_TIME_US);

    // configuration
    logic [1:0]  enables_reg;
    logic [21:0] cal_reg;
    logic [15:0] min_mv_reg, ref_mv_reg, sens_reg;
    logic [11:0] base_dt_reg;
    logic [23:0] grace_reg, timeout_reg;

    // latched input word
    logic [31:0] now_reg;
    logic [11:0] raw_reg;
    logic        adc_valid_reg, acc_on_reg, disp_reg;

    seq_state_t  state_reg, state_next;
    logic        accept, mul_en, commit;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;

    logic [15:0]        mv_reg, mv_sat, volt;
    logic signed [16:0] diff_reg, diff_next;
    logic signed [34:0] num;
    logic [24:0]        quot;
    logic [11:0]        dt_calc;
    logic               measure;

    acc_status_t status_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] out_mv_reg;
    logic [11:0] out_dt_reg;
    acc_status_t out_status_reg;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enables_reg <= 2'd3;
            cal_reg     <= 22'd301466;
            min_mv_reg  <= 16'd6000;
            ref_mv_reg  <= 16'd14000;
            base_dt_reg <= 12'd1000;
            sens_reg    <= 16'd307;
            grace_reg   <= 24'd2000;
            timeout_reg <= 24'd30000;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ENABLES:    enables_reg <= cfg_wdata[1:0];
                CFG_CAL_FACTOR: cal_reg     <= cfg_wdata[21:0];
                CFG_MIN_MV:     min_mv_reg  <= cfg_wdata[15:0];
                CFG_REF_MV:     ref_mv_reg  <= cfg_wdata[15:0];
                CFG_BASE_DT:    base_dt_reg <= cfg_wdata[11:0];
                CFG_DT_SENS:    sens_reg    <= cfg_wdata[15:0];
                CFG_GRACE:      grace_reg   <= cfg_wdata;
                CFG_TIMEOUT:    timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg       <= s_now_ms;
            raw_reg       <= s_adc_raw;
            adc_valid_reg <= s_adc_valid;
            acc_on_reg    <= s_acc_on;
            disp_reg      <= s_display_ready;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mul_en     = 1'b0;
        commit     = 1'b0;
        op_a       = $signed({1'b0, cal_reg});
        op_b       = $signed({5'd0, raw_reg});
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MUL_MV;
                end
            end
            ST_MUL_MV: begin
                mul_en     = 1'b1;
                state_next = ST_VOLT;
            end
            ST_VOLT: begin
                state_next = ST_MUL_DT;
            end
            ST_MUL_DT: begin
                mul_en     = 1'b1;
                op_a       = OPA_W'(diff_reg);
                op_b       = $signed({1'b0, sens_reg});
                state_next = ST_CORR;
            end
            ST_CORR: begin
                // hold the finished word until the output register is free
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    bdsm_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // saturate the scaled sample, pick the correction voltage
    always_comb begin
        mv_sat = (|prod[33:32]) ? 16'hFFFF : prod[31:16];
        volt   = (mv_sat <= min_mv_reg) ? ref_mv_reg : mv_sat;
        diff_next = $signed({1'b0, ref_mv_reg}) - $signed({1'b0, volt});
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_VOLT) begin
            mv_reg   <= mv_sat;
            diff_reg <= diff_next;
        end
    end

    // base plus correction, floor to microseconds, clamp
    always_comb begin
        num  = $signed({13'd0, base_dt_reg, 10'd0}) + prod[34:0];
        quot = num[34:10];
        if (num[34] || num == 35'sd0) begin
            dt_calc = 12'd0;
        end else if (quot > {13'd0, MaxDt}) begin
            dt_calc = MaxDt;
        end else begin
            dt_calc = quot[11:0];
        end
    end

    assign measure = enables_reg[0] && adc_valid_reg;

    bdsm_acc u_acc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .commit        (commit),
        .supervise_en  (enables_reg[1]),
        .now_ms        (now_reg),
        .acc_on        (acc_on_reg),
        .display_ready (disp_reg),
        .grace_ms      (grace_reg),
        .timeout_ms    (timeout_reg),
        .status_next   (status_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_mv_reg     <= measure ? mv_reg : 16'd0;
            out_dt_reg     <= measure ? dt_calc : 12'd0;
            out_status_reg <= status_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_battery_mv    = out_mv_reg;
    assign m_dead_time_us  = out_dt_reg;
    assign m_acc_present   = out_status_reg.power_up;
    assign m_dormant       = out_status_reg.dormant;
    assign m_acc_just_lost = out_status_reg.fresh_loss;
    assign m_loss_pending  = out_status_reg.loss_pending;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_MUL_MV)
        else $error("accepted word did not start the sequencer");

    a_dt_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dead_time_us <= MaxDt)
        else $error("dead time above limit");

    a_dormant_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dormant |-> !m_acc_just_lost && !m_loss_pending)
        else $error("loss flags still set while dormant");

    a_present_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_acc_present |-> !m_dormant && !m_acc_just_lost && !m_loss_pending)
        else $error("sleep flags set while ACC present");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> !m_valid_reg || m_ready)
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire
